@@ hdl/fsa_pkg.sv @@
// shared types, constants and pipeline control for the flight status annunciator
`timescale 1ns / 1ps
package fsa_pkg;

  // pipeline stages, index into the load and valid vectors
  localparam int STAGES   = 7;
  localparam int ST_IN    = 0;
  localparam int ST_CELL  = 1;
  localparam int ST_CLASS = 2;
  localparam int ST_SEL   = 3;
  localparam int ST_EL    = 4;
  localparam int ST_MOD   = 5;
  localparam int ST_OUT   = 6;

  // field widths
  localparam int TIME_W = 32;
  localparam int MV_W   = 16;
  localparam int THR_W  = 13;
  localparam int OVR_W  = 4;
  localparam int COL_W  = 8;
  localparam int HZ_W   = 12;
  localparam int CELL_W = 5;
  localparam int PROD_W = THR_W + CELL_W;

  // config register indexes and address width
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_CELLS = 2'd0;
  localparam logic [1:0] REG_CRIT  = 2'd1;
  localparam logic [1:0] REG_WARN  = 2'd2;
  localparam logic [THR_W-1:0] CRIT_RESET = 13'd3300;
  localparam logic [THR_W-1:0] WARN_RESET = 13'd3500;

  // cell detection: round(mv / 3700) by reciprocal multiply and one correction
  localparam int CELL_MV    = 3700;
  localparam int CELL_HALF  = 1850;
  localparam int CELL_SHIFT = 20;
  localparam int CELL_RECIP = (1 << CELL_SHIFT) / CELL_MV;
  localparam int CX_W       = MV_W + 1;
  localparam int CRECIP_W   = 9;
  localparam int CQ_W       = 6;

  // remainders of time divisions are kept modulo 2^MOD_W (twice every divisor fits)
  localparam int MOD_W = 11;

  // led blink half periods
  localparam int BLINK_FS_MS   = 150;
  localparam int BLINK_CRIT_MS = 200;
  localparam int BLINK_WARN_MS = 500;
  localparam logic [TIME_W-1:0] RECIP_FS   = 32'((64'd1 << 32) / BLINK_FS_MS);
  localparam logic [TIME_W-1:0] RECIP_CRIT = 32'((64'd1 << 32) / BLINK_CRIT_MS);
  localparam logic [TIME_W-1:0] RECIP_WARN = 32'((64'd1 << 32) / BLINK_WARN_MS);

  // led levels
  localparam logic [COL_W-1:0] LED_FULL  = 8'd255;
  localparam logic [COL_W-1:0] LED_AMBER = 8'd40;
  localparam logic [COL_W-1:0] LED_DIM   = 8'd60;

  // buzzer timing
  localparam logic [HZ_W-1:0]   ARM_HZ      = 12'd2000;
  localparam logic [TIME_W-1:0] ARM_MS      = 32'd120;
  localparam logic [HZ_W-1:0]   DISARM_HZ   = 12'd1500;
  localparam logic [TIME_W-1:0] DISARM_ON1  = 32'd80;
  localparam logic [TIME_W-1:0] DISARM_OFF  = 32'd160;
  localparam logic [TIME_W-1:0] DISARM_END  = 32'd240;
  localparam logic [HZ_W-1:0]   BATT_HZ     = 12'd2500;
  localparam int                BATT_PERIOD = 1000;
  localparam int                BATT_ON_MS  = 150;
  localparam logic [HZ_W-1:0]   LOST_HZ     = 12'd3000;
  localparam int                LOST_PERIOD = 400;
  localparam int                LOST_ON_MS  = 200;
  localparam logic [TIME_W-1:0] RECIP_BATT  = 32'((64'd1 << 32) / BATT_PERIOD);
  localparam logic [TIME_W-1:0] RECIP_LOST  = 32'((64'd1 << 32) / LOST_PERIOD);

  typedef enum logic [2:0] {
    PAT_NONE    = 3'd0,
    PAT_ARM     = 3'd1,
    PAT_DISARM  = 3'd2,
    PAT_BATTERY = 3'd3,
    PAT_LOST    = 3'd4
  } pat_t;

  typedef enum logic [1:0] {
    TONE_FIXED   = 2'd0,
    TONE_BATTERY = 2'd1,
    TONE_LOST    = 2'd2
  } tone_mode_t;

  typedef enum logic [1:0] {
    BAT_UNKNOWN  = 2'd0,
    BAT_OK       = 2'd1,
    BAT_WARNING  = 2'd2,
    BAT_CRITICAL = 2'd3
  } bat_status_t;

  typedef struct packed {
    logic [STAGES-1:0] load;
    logic [STAGES-1:0] valid;
  } pipe_ctl_t;

  typedef struct packed {
    logic [OVR_W-1:0] cells_override;
    logic [THR_W-1:0] crit_mv;
    logic [THR_W-1:0] warn_mv;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    bat_status_t      status;
  } led_t;

  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic              failsafe;
    logic              armed;
    logic              crit;
    led_t              led;
  } front_t;

endpackage

@@ hdl/fsa_front.sv @@
// battery classification and led color stages
`timescale 1ns / 1ps
module fsa_front (
  input  logic                          clk,
  input  fsa_pkg::pipe_ctl_t            ctl,
  input  fsa_pkg::cfg_t                 cfg,
  input  logic [fsa_pkg::TIME_W-1:0]    now_ms,
  input  logic                          failsafe,
  input  logic                          armed,
  input  logic [fsa_pkg::MV_W-1:0]      battery_mv,
  output fsa_pkg::front_t               item
);

  localparam int TW = fsa_pkg::TIME_W;
  localparam int MW = fsa_pkg::MOD_W;

  // input stage
  logic [TW-1:0]            now1_r;
  logic                     fs1_r, arm1_r;
  logic [fsa_pkg::MV_W-1:0] mv1_r;

  always_ff @(posedge clk) begin
    if (ctl.load[fsa_pkg::ST_IN]) begin
      now1_r <= now_ms;
      fs1_r  <= failsafe;
      arm1_r <= armed;
      mv1_r  <= battery_mv;
    end
  end

  // reciprocal products, quotient estimates low or exact
  logic [fsa_pkg::CX_W-1:0]                      x1;
  logic [fsa_pkg::CX_W+fsa_pkg::CRECIP_W-1:0]    pc1;
  logic [2*TW-1:0]                               pf1, pa1, pw1;

  assign x1  = {1'b0, mv1_r} + fsa_pkg::CX_W'(fsa_pkg::CELL_HALF);
  assign pc1 = (fsa_pkg::CX_W + fsa_pkg::CRECIP_W)'(x1) *
               (fsa_pkg::CX_W + fsa_pkg::CRECIP_W)'(fsa_pkg::CELL_RECIP);
  assign pf1 = (2*TW)'(now1_r) * (2*TW)'(fsa_pkg::RECIP_FS);
  assign pa1 = (2*TW)'(now1_r) * (2*TW)'(fsa_pkg::RECIP_CRIT);
  assign pw1 = (2*TW)'(now1_r) * (2*TW)'(fsa_pkg::RECIP_WARN);

  logic [TW-1:0]            now2_r;
  logic                     fs2_r, arm2_r;
  logic [fsa_pkg::MV_W-1:0] mv2_r;
  logic [fsa_pkg::CQ_W-1:0] qc2_r;
  logic [MW-1:0]            qf2_r, qa2_r, qw2_r;

  always_ff @(posedge clk) begin
    if (ctl.load[fsa_pkg::ST_CELL]) begin
      now2_r <= now1_r;
      fs2_r  <= fs1_r;
      arm2_r <= arm1_r;
      mv2_r  <= mv1_r;
      qc2_r  <= pc1[fsa_pkg::CELL_SHIFT +: fsa_pkg::CQ_W];
      qf2_r  <= pf1[TW +: MW];
      qa2_r  <= pa1[TW +: MW];
      qw2_r  <= pw1[TW +: MW];
    end
  end

  // quotient correction: cell count and blink phases
  logic [fsa_pkg::CX_W-1:0]   x2, rc2;
  logic [fsa_pkg::CQ_W-1:0]   auto2;
  logic [fsa_pkg::CELL_W-1:0] cells2;
  logic [MW-1:0]              rf2, ra2, rw2;
  logic                       on_fs2, on_crit2, on_warn2;

  assign x2    = {1'b0, mv2_r} + fsa_pkg::CX_W'(fsa_pkg::CELL_HALF);
  assign rc2   = x2 - fsa_pkg::CX_W'(fsa_pkg::CX_W'(qc2_r) * fsa_pkg::CX_W'(fsa_pkg::CELL_MV));
  assign auto2 = qc2_r + fsa_pkg::CQ_W'(rc2 >= fsa_pkg::CX_W'(fsa_pkg::CELL_MV));

  always_comb begin
    if (cfg.cells_override != '0) begin
      cells2 = fsa_pkg::CELL_W'(cfg.cells_override);
    end else if (auto2 == '0) begin
      cells2 = fsa_pkg::CELL_W'(1);
    end else begin
      cells2 = auto2[fsa_pkg::CELL_W-1:0];
    end
  end

  assign rf2 = now2_r[MW-1:0] - MW'(qf2_r * MW'(fsa_pkg::BLINK_FS_MS));
  assign ra2 = now2_r[MW-1:0] - MW'(qa2_r * MW'(fsa_pkg::BLINK_CRIT_MS));
  assign rw2 = now2_r[MW-1:0] - MW'(qw2_r * MW'(fsa_pkg::BLINK_WARN_MS));

  // on while the corrected quotient is even
  assign on_fs2   = ~(qf2_r[0] ^ (rf2 >= MW'(fsa_pkg::BLINK_FS_MS)));
  assign on_crit2 = ~(qa2_r[0] ^ (ra2 >= MW'(fsa_pkg::BLINK_CRIT_MS)));
  assign on_warn2 = ~(qw2_r[0] ^ (rw2 >= MW'(fsa_pkg::BLINK_WARN_MS)));

  logic [TW-1:0]              now3_r;
  logic                       fs3_r, arm3_r;
  logic [fsa_pkg::MV_W-1:0]   mv3_r;
  logic [fsa_pkg::CELL_W-1:0] cells3_r;
  logic                       on_fs3_r, on_crit3_r, on_warn3_r;

  always_ff @(posedge clk) begin
    if (ctl.load[fsa_pkg::ST_CLASS]) begin
      now3_r     <= now2_r;
      fs3_r      <= fs2_r;
      arm3_r     <= arm2_r;
      mv3_r      <= mv2_r;
      cells3_r   <= cells2;
      on_fs3_r   <= on_fs2;
      on_crit3_r <= on_crit2;
      on_warn3_r <= on_warn2;
    end
  end

  // thresholds scaled by cell count, then status and led color
  logic [fsa_pkg::PROD_W-1:0] pcrit3, pwarn3;
  logic                       known3, crit3, warn3;
  fsa_pkg::led_t              led3;

  assign pcrit3 = fsa_pkg::PROD_W'(cfg.crit_mv) * fsa_pkg::PROD_W'(cells3_r);
  assign pwarn3 = fsa_pkg::PROD_W'(cfg.warn_mv) * fsa_pkg::PROD_W'(cells3_r);
  assign known3 = (mv3_r != '0);
  assign crit3  = known3 && (fsa_pkg::PROD_W'(mv3_r) < pcrit3);
  assign warn3  = known3 && !crit3 && (fsa_pkg::PROD_W'(mv3_r) < pwarn3);

  always_comb begin
    led3 = '0;
    if (!known3) begin
      led3.status = fsa_pkg::BAT_UNKNOWN;
    end else if (crit3) begin
      led3.status = fsa_pkg::BAT_CRITICAL;
    end else if (warn3) begin
      led3.status = fsa_pkg::BAT_WARNING;
    end else begin
      led3.status = fsa_pkg::BAT_OK;
    end
    if (fs3_r) begin
      led3.red = on_fs3_r ? fsa_pkg::LED_FULL : '0;
    end else if (crit3) begin
      led3.red   = on_crit3_r ? fsa_pkg::LED_FULL : '0;
      led3.green = on_crit3_r ? fsa_pkg::LED_AMBER : '0;
    end else if (arm3_r) begin
      led3.green = (warn3 && !on_warn3_r) ? fsa_pkg::LED_DIM : fsa_pkg::LED_FULL;
    end else begin
      led3.blue = fsa_pkg::LED_FULL;
    end
  end

  fsa_pkg::front_t item_r;

  always_ff @(posedge clk) begin
    if (ctl.load[fsa_pkg::ST_SEL]) begin
      item_r.now      <= now3_r;
      item_r.failsafe <= fs3_r;
      item_r.armed    <= arm3_r;
      item_r.crit     <= crit3;
      item_r.led      <= led3;
    end
  end

  assign item = item_r;

endmodule

@@ hdl/fsa_buzzer.sv @@
// buzzer pattern selection, pattern state and tone stages
`timescale 1ns / 1ps
module fsa_buzzer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fsa_pkg::pipe_ctl_t          ctl,
  input  fsa_pkg::front_t             item,
  output logic [fsa_pkg::HZ_W-1:0]    tone_hz,
  output fsa_pkg::led_t               led
);

  localparam int TW = fsa_pkg::TIME_W;
  localparam int MW = fsa_pkg::MOD_W;

  // pattern state
  fsa_pkg::pat_t  pat_r, pat_nxt, pat_sel;
  logic [TW-1:0]  start_r, start_sel;
  logic           was_armed_r;
  logic [TW-1:0]  el;
  logic           upd;

  assign upd = ctl.load[fsa_pkg::ST_EL] && ctl.valid[fsa_pkg::ST_SEL];

  // selection by priority; reselecting the running pattern keeps its start
  always_comb begin
    pat_sel   = pat_r;
    start_sel = start_r;
    if (item.failsafe) begin
      if (pat_r != fsa_pkg::PAT_LOST) begin
        pat_sel   = fsa_pkg::PAT_LOST;
        start_sel = item.now;
      end
    end else if (item.crit) begin
      if (pat_r != fsa_pkg::PAT_BATTERY) begin
        pat_sel   = fsa_pkg::PAT_BATTERY;
        start_sel = item.now;
      end
    end else if (item.armed && !was_armed_r) begin
      if (pat_r != fsa_pkg::PAT_ARM) begin
        pat_sel   = fsa_pkg::PAT_ARM;
        start_sel = item.now;
      end
    end else if (!item.armed && was_armed_r) begin
      if (pat_r != fsa_pkg::PAT_DISARM) begin
        pat_sel   = fsa_pkg::PAT_DISARM;
        start_sel = item.now;
      end
    end else if (pat_r == fsa_pkg::PAT_LOST || pat_r == fsa_pkg::PAT_BATTERY) begin
      pat_sel = fsa_pkg::PAT_NONE;
    end
  end

  assign el = item.now - start_sel;

  // next state: one-shot patterns end on their own
  always_comb begin
    unique case (pat_sel)
      fsa_pkg::PAT_ARM:     pat_nxt = (el < fsa_pkg::ARM_MS) ? pat_sel : fsa_pkg::PAT_NONE;
      fsa_pkg::PAT_DISARM:  pat_nxt = (el < fsa_pkg::DISARM_END) ? pat_sel : fsa_pkg::PAT_NONE;
      fsa_pkg::PAT_BATTERY: pat_nxt = pat_sel;
      fsa_pkg::PAT_LOST:    pat_nxt = pat_sel;
      default:              pat_nxt = fsa_pkg::PAT_NONE;
    endcase
  end

  // outputs: fixed tone, or a periodic pattern finished downstream
  fsa_pkg::tone_mode_t      mode4;
  logic [fsa_pkg::HZ_W-1:0] hz4;

  always_comb begin
    mode4 = fsa_pkg::TONE_FIXED;
    hz4   = '0;
    unique case (pat_sel)
      fsa_pkg::PAT_ARM: begin
        hz4 = (el < fsa_pkg::ARM_MS) ? fsa_pkg::ARM_HZ : '0;
      end
      fsa_pkg::PAT_DISARM: begin
        if (el < fsa_pkg::DISARM_ON1) begin
          hz4 = fsa_pkg::DISARM_HZ;
        end else if (el < fsa_pkg::DISARM_OFF) begin
          hz4 = '0;
        end else if (el < fsa_pkg::DISARM_END) begin
          hz4 = fsa_pkg::DISARM_HZ;
        end
      end
      fsa_pkg::PAT_BATTERY: mode4 = fsa_pkg::TONE_BATTERY;
      fsa_pkg::PAT_LOST:    mode4 = fsa_pkg::TONE_LOST;
      default:              mode4 = fsa_pkg::TONE_FIXED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r       <= fsa_pkg::PAT_NONE;
      start_r     <= '0;
      was_armed_r <= 1'b0;
    end else if (upd) begin
      pat_r       <= pat_nxt;
      start_r     <= start_sel;
      was_armed_r <= item.armed;
    end
  end

  // elapsed time stage
  logic [TW-1:0]            el5_r;
  fsa_pkg::tone_mode_t      mode5_r;
  logic [fsa_pkg::HZ_W-1:0] hz5_r;
  fsa_pkg::led_t            led5_r;

  always_ff @(posedge clk) begin
    if (ctl.load[fsa_pkg::ST_EL]) begin
      el5_r   <= el;
      mode5_r <= mode4;
      hz5_r   <= hz4;
      led5_r  <= item.led;
    end
  end

  // period quotient estimates
  logic [2*TW-1:0] pb5, pl5;

  assign pb5 = (2*TW)'(el5_r) * (2*TW)'(fsa_pkg::RECIP_BATT);
  assign pl5 = (2*TW)'(el5_r) * (2*TW)'(fsa_pkg::RECIP_LOST);

  logic [MW-1:0]            el6_r, qb6_r, ql6_r;
  fsa_pkg::tone_mode_t      mode6_r;
  logic [fsa_pkg::HZ_W-1:0] hz6_r;
  fsa_pkg::led_t            led6_r;

  always_ff @(posedge clk) begin
    if (ctl.load[fsa_pkg::ST_MOD]) begin
      el6_r   <= el5_r[MW-1:0];
      qb6_r   <= pb5[TW +: MW];
      ql6_r   <= pl5[TW +: MW];
      mode6_r <= mode5_r;
      hz6_r   <= hz5_r;
      led6_r  <= led5_r;
    end
  end

  // remainder within the period, one correction step
  logic [MW-1:0] rb6, rl6, rbc6, rlc6;

  assign rb6  = el6_r - MW'(qb6_r * MW'(fsa_pkg::BATT_PERIOD));
  assign rl6  = el6_r - MW'(ql6_r * MW'(fsa_pkg::LOST_PERIOD));
  assign rbc6 = (rb6 >= MW'(fsa_pkg::BATT_PERIOD)) ? rb6 - MW'(fsa_pkg::BATT_PERIOD) : rb6;
  assign rlc6 = (rl6 >= MW'(fsa_pkg::LOST_PERIOD)) ? rl6 - MW'(fsa_pkg::LOST_PERIOD) : rl6;

  always_comb begin
    case (mode6_r)
      fsa_pkg::TONE_BATTERY:
        tone_hz = (rbc6 < MW'(fsa_pkg::BATT_ON_MS)) ? fsa_pkg::BATT_HZ : '0;
      fsa_pkg::TONE_LOST:
        tone_hz = (rlc6 < MW'(fsa_pkg::LOST_ON_MS)) ? fsa_pkg::LOST_HZ : '0;
      default:
        tone_hz = hz6_r;
    endcase
  end

  assign led = led6_r;

endmodule

@@ hdl/flight_status_annunciator.sv @@
// Flight status annunciator top level: stream ports, config registers, pipeline control.
// Items pass the input, cell, class, select, elapsed, modulo and output stages in order.
// Throughput: one item per cycle unless out_tready stalls; the pattern state loop closes at stage 4.
// Each stage holds its item until the next stage frees, so a waiting result stalls only
// the stages behind it while empty stages keep taking items.
// Reset (rst_n low, synchronous) empties the pipeline, sets the buzzer pattern to none with
// start time 0, and loads the registers with override 0, critical 3300 mV, warning 3500 mV.
`timescale 1ns / 1ps
module flight_status_annunciator (
  input  logic                         clk,
  input  logic                         rst_n,
  // input items
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [55:0]                  in_tdata,   // now_ms[31:0], failsafe, armed, battery_mv[15:0], pad
  // result items
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [39:0]                  out_tdata,  // red, green, blue, tone_hz[11:0], battery_status[1:0], pad
  // config port
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fsa_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int NS = fsa_pkg::STAGES;

  // config registers
  fsa_pkg::cfg_t cfg_r;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[fsa_pkg::ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cells_override <= '0;
      cfg_r.crit_mv        <= fsa_pkg::CRIT_RESET;
      cfg_r.warn_mv        <= fsa_pkg::WARN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        fsa_pkg::REG_CELLS: cfg_r.cells_override <= cfg_pwdata[fsa_pkg::OVR_W-1:0];
        fsa_pkg::REG_CRIT:  cfg_r.crit_mv        <= cfg_pwdata[fsa_pkg::THR_W-1:0];
        fsa_pkg::REG_WARN:  cfg_r.warn_mv        <= cfg_pwdata[fsa_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      fsa_pkg::REG_CELLS: cfg_prdata = 32'(cfg_r.cells_override);
      fsa_pkg::REG_CRIT:  cfg_prdata = 32'(cfg_r.crit_mv);
      fsa_pkg::REG_WARN:  cfg_prdata = 32'(cfg_r.warn_mv);
      default:            cfg_prdata = '0;
    endcase
  end

  // per-stage valid and load chain
  logic [NS-1:0]      valid_r;
  logic [NS:0]        load_chain;
  fsa_pkg::pipe_ctl_t ctl;

  always_comb begin
    load_chain[NS] = out_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      load_chain[k] = !valid_r[k] || load_chain[k+1];
    end
  end

  assign ctl.load  = load_chain[NS-1:0];
  assign ctl.valid = valid_r;
  assign in_tready = load_chain[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (load_chain[0]) begin
        valid_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (load_chain[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // classification and color
  fsa_pkg::front_t item;

  fsa_front u_front (
    .clk        (clk),
    .ctl        (ctl),
    .cfg        (cfg_r),
    .now_ms     (in_tdata[31:0]),
    .failsafe   (in_tdata[32]),
    .armed      (in_tdata[33]),
    .battery_mv (in_tdata[49:34]),
    .item       (item)
  );

  // buzzer
  logic [fsa_pkg::HZ_W-1:0] tone_hz;
  fsa_pkg::led_t            led;

  fsa_buzzer u_buzzer (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .item    (item),
    .tone_hz (tone_hz),
    .led     (led)
  );

  // output register
  logic [39:0] out_data_r;

  always_ff @(posedge clk) begin
    if (ctl.load[fsa_pkg::ST_OUT]) begin
      out_data_r <= {2'b00, led.status, tone_hz, led.blue, led.green, led.red};
    end
  end

  assign out_tvalid = valid_r[fsa_pkg::ST_OUT];
  assign out_tdata  = out_data_r;

endmodule
